/* sv/s256h_pkg.sv */
// Package for the SHA-256 hash unit: state types, constants and round functions.
`default_nettype none
package s256h_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_COMPRESS,
		ST_ADD,
		ST_OUT
	} s256h_state_t;

	typedef enum logic [1:0] {
		PH_WORD,
		PH_MARK,
		PH_ZERO,
		PH_LENLO
	} s256h_phase_t;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned BLK_WORDS = 16;
	localparam int unsigned DIG_WORDS = 8;
	localparam int unsigned ROUNDS    = 64;

	localparam logic [31:0] PAD_MARK = 32'h8000_0000;

	localparam logic [31:0] INIT_H [0:7] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [0:63] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage
`default_nettype wire

/* sv/sha256_message_hash_unit.sv */
// SHA-256 message hash unit: block buffer, padding sequencer, round unit, digest output.
// A message word without the end mark is written into the block buffer; when it
// completes a 512-bit block, the single round unit runs the compression (one round per
// cycle, the schedule word made alongside in a 16-word shift line) and the working
// registers are then folded into the chaining state. The end-marked word then runs the
// padding sequencer, which pushes one padding word per cycle into the block buffer and
// starts a compression each time a block fills (one or two blocks), after which the
// eight digest words leave one per cycle, most significant first, while m_tready is high.
// The input side is not ready from the end-marked word until the last digest word is
// taken; the block then starts from the initial chaining values.
`default_nettype none
module sha256_message_hash_unit
	import s256h_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [39:0] s_tdata,   // data_word[31:0], byte_count[34:32], zero fill
	input  wire logic        s_tlast,   // end_of_message
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [39:0] m_tdata,   // digest_word[31:0], word_index[34:32], zero fill
	output      logic        m_tlast    // last_word
);

	s256h_state_t state_q, state_d;
	s256h_phase_t phase_q;

	logic [3:0]  fill_q;
	logic [5:0]  round_q;
	logic [63:0] bitcnt_q;
	logic [31:0] pad_word_q;
	logic        pad_full_q;
	logic        pad_q;
	logic        final_q;
	logic [2:0]  out_idx_q;
	logic [31:0] chain_q [0:7];
	logic [31:0] v_q [0:7];
	logic [31:0] w_q [0:15];

	logic        in_acc;
	logic        push_en;
	logic [31:0] push_word;
	logic [2:0]  byte_cnt;
	logic [2:0]  n_eff;
	logic [31:0] data_in;
	logic [31:0] pad_word_d;
	logic [31:0] t1, t2, sched_new;

	assign data_in  = s_tdata[31:0];
	assign byte_cnt = s_tdata[34:32];
	assign in_acc   = s_tvalid && s_tready;
	assign n_eff    = (byte_cnt > 3'd4) ? 3'd4 : byte_cnt;

	// final word: leading bytes kept, then the 0x80 marker if fewer than four bytes
	always_comb begin
		case (n_eff)
			3'd0:    pad_word_d = PAD_MARK;
			3'd1:    pad_word_d = {data_in[31:24], 24'h80_0000};
			3'd2:    pad_word_d = {data_in[31:16], 16'h8000};
			3'd3:    pad_word_d = {data_in[31:8], 8'h80};
			default: pad_word_d = data_in;
		endcase
	end

	// round unit
	assign t1 = v_q[7] + big_sigma1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ ROUND_K[round_q] + w_q[0];
	assign t2 = big_sigma0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	assign sched_new = small_sigma1(w_q[14]) + w_q[9] + small_sigma0(w_q[1]) + w_q[0];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (s_tlast)
						state_d = ST_PAD;
					else if (fill_q == 4'd15)
						state_d = ST_COMPRESS;
				end
			end
			ST_PAD: begin
				if (fill_q == 4'd15)
					state_d = ST_COMPRESS;
			end
			ST_COMPRESS: begin
				if (round_q == 6'd63)
					state_d = ST_ADD;
			end
			ST_ADD: begin
				if (final_q)
					state_d = ST_OUT;
				else if (pad_q)
					state_d = ST_PAD;
				else
					state_d = ST_IDLE;
			end
			ST_OUT: begin
				if (m_tready && out_idx_q == 3'd7)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and buffer write select
	always_comb begin
		s_tready  = 1'b0;
		m_tvalid  = 1'b0;
		push_en   = 1'b0;
		push_word = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready  = 1'b1;
				push_en   = s_tvalid && !s_tlast;
				push_word = data_in;
			end
			ST_PAD: begin
				push_en = 1'b1;
				case (phase_q)
					PH_WORD:  push_word = pad_word_q;
					PH_MARK:  push_word = PAD_MARK;
					PH_ZERO:  push_word = (fill_q == 4'd14) ? bitcnt_q[63:32] : '0;
					PH_LENLO: push_word = bitcnt_q[31:0];
					default:  push_word = '0;
				endcase
			end
			ST_OUT: begin
				m_tvalid = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign m_tdata = {5'b0, out_idx_q, chain_q[out_idx_q]};
	assign m_tlast = (out_idx_q == 3'd7);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_q   <= PH_WORD;
			fill_q    <= '0;
			round_q   <= '0;
			bitcnt_q  <= '0;
			pad_full_q <= 1'b0;
			pad_q     <= 1'b0;
			final_q   <= 1'b0;
			out_idx_q <= '0;
			for (int i = 0; i < 8; i++)
				chain_q[i] <= INIT_H[i];
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				if (s_tlast) begin
					bitcnt_q   <= bitcnt_q + {58'b0, n_eff, 3'b000};
					pad_full_q <= (n_eff == 3'd4);
					pad_q      <= 1'b1;
					phase_q    <= PH_WORD;
				end else begin
					bitcnt_q <= bitcnt_q + 64'd32;
				end
			end
			if (push_en)
				fill_q <= fill_q + 4'd1;
			if (state_q == ST_PAD) begin
				case (phase_q)
					PH_WORD: phase_q <= pad_full_q ? PH_MARK : PH_ZERO;
					PH_MARK: phase_q <= PH_ZERO;
					PH_ZERO: begin
						if (fill_q == 4'd14)
							phase_q <= PH_LENLO;
					end
					PH_LENLO: final_q <= 1'b1;
					default: phase_q <= PH_WORD;
				endcase
			end
			if (state_q == ST_COMPRESS)
				round_q <= round_q + 6'd1;
			if (state_q == ST_ADD) begin
				for (int i = 0; i < 8; i++)
					chain_q[i] <= chain_q[i] + v_q[i];
			end
			if (state_q == ST_OUT && m_tready) begin
				out_idx_q <= out_idx_q + 3'd1;
				if (out_idx_q == 3'd7) begin
					for (int i = 0; i < 8; i++)
						chain_q[i] <= INIT_H[i];
					bitcnt_q <= '0;
					pad_q    <= 1'b0;
					final_q  <= 1'b0;
				end
			end
		end
	end

	// block buffer / schedule shift line and working registers
	always_ff @(posedge clk) begin
		if (push_en) begin
			for (int i = 0; i < 15; i++)
				w_q[i] <= w_q[i+1];
			w_q[15] <= push_word;
			if (fill_q == 4'd15) begin
				for (int i = 0; i < 8; i++)
					v_q[i] <= chain_q[i];
			end
		end else if (state_q == ST_COMPRESS) begin
			for (int i = 0; i < 15; i++)
				w_q[i] <= w_q[i+1];
			w_q[15] <= sched_new;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && s_tlast)
			pad_word_q <= pad_word_d;
	end

`ifndef SYNTHESIS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input ready while digest is being sent");

	a_round_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_COMPRESS) |-> (round_q == 6'd0))
		else $error("round counter not cleared outside compression");

	a_full_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMPRESS) |-> (fill_q == 4'd0))
		else $error("compression started on a partial block");

	a_digest_run: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
		else $error("digest run broken before last word");

	a_digest_end: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> (s_tready && fill_q == 4'd0 && bitcnt_q == 64'd0))
		else $error("unit not restarted after digest");
`endif

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for sha256_message_hash_unit: directed and random messages vs a SHA-256 predictor.
`timescale 1ns / 1ps
module tb_top;
	import s256h_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned RANDOM_ITEMS = 290;
	localparam int unsigned DRAIN_AFTER = 260;
	localparam int unsigned TAIL_CYCLES = 100;

	localparam logic [31:0] SHA_IV [0:7] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] SHA_K [0:63] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [255:0] DIGEST_EMPTY =
		256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
	localparam logic [255:0] DIGEST_ABC =
		256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_slot_t;

	typedef struct packed {
		logic [31:0]  word;
		logic [2:0]   nbytes;
		logic         eom;
		logic         has_digest;
		logic [255:0] digest;
	} msg_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tlast;

	sha256_message_hash_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// hash state kept by the predictor
	logic [63:0] msg_bits;
	logic [31:0] blk_buf [0:15];
	logic [31:0] chain [0:7];
	logic [3:0]  fill;

	digest_slot_t pending_digest_q [$];
	msg_row_t     directed_rows [$];
	digest_slot_t head;
	int unsigned  errors = 0;
	int unsigned  cycles = 0;
	int unsigned  items_sent = 0;
	bit           drain_phase = 1'b0;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic compress_block();
		logic [31:0] w [0:63];
		logic [31:0] v [0:7];
		logic [31:0] s0, s1, t1, t2;
		int i;
		for (i = 0; i < 16; i++)
			w[i] = blk_buf[i];
		for (i = 16; i < 64; i++) begin
			s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = w[i-16] + s0 + w[i-7] + s1;
		end
		for (i = 0; i < 8; i++)
			v[i] = chain[i];
		for (i = 0; i < 64; i++) begin
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + w[i];
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (i = 0; i < 8; i++)
			chain[i] = chain[i] + v[i];
	endtask

	task automatic push_word(input logic [31:0] w);
		blk_buf[fill] = w;
		fill = fill + 4'd1;
		if (fill == 4'd0)
			compress_block();
	endtask

	task automatic hash_restart();
		int i;
		for (i = 0; i < 8; i++)
			chain[i] = SHA_IV[i];
		msg_bits = '0;
		fill = '0;
	endtask

	// absorbs one item; on the end mark pads, finishes and returns the digest
	task automatic hash_absorb(input logic [31:0] w, input logic [2:0] nbytes, input logic eom,
			output bit done, output logic [255:0] digest);
		int unsigned n;
		int i;
		done = 1'b0;
		digest = '0;
		n = (nbytes > 3'd4 || !eom) ? 4 : int'(nbytes);
		msg_bits = msg_bits + 64'(8 * n);
		if (!eom) begin
			push_word(w);
			return;
		end
		if (n == 4) begin
			push_word(w);
			push_word(32'h8000_0000);
		end else begin
			// keep the leading bytes, pad marker right after them
			push_word((w & ~(32'hFFFF_FFFF >> (8 * n))) | (32'h8000_0000 >> (8 * n)));
		end
		while (fill != 4'd14)
			push_word(32'h0);
		push_word(msg_bits[63:32]);
		push_word(msg_bits[31:0]);
		for (i = 0; i < 8; i++)
			digest[255 - 32 * i -: 32] = chain[i];
		done = 1'b1;
		hash_restart();
	endtask

	// drives one item from a falling edge, returns at the falling edge after acceptance
	task automatic send_item(input logic [31:0] w, input logic [2:0] nbytes, input logic eom,
			input bit has_digest, input logic [255:0] typed_digest, input int unsigned gap);
		bit done;
		logic [255:0] digest;
		digest_slot_t slot;
		int i;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'b0, nbytes, w};
		s_tlast <= eom;
		do @(posedge clk); while (!s_tready);
		hash_absorb(w, nbytes, eom, done, digest);
		if (done) begin
			if (has_digest)
				digest = typed_digest;
			for (i = 0; i < 8; i++) begin
				slot.word = digest[255 - 32 * i -: 32];
				slot.idx = 3'(i);
				slot.last = (i == 7);
				pending_digest_q.push_back(slot);
			end
		end
		items_sent++;
		@(negedge clk);
	endtask

	task automatic add_row(input logic [31:0] w, input logic [2:0] nbytes, input logic eom,
			input bit has_digest, input logic [255:0] digest);
		msg_row_t r;
		r.word = w;
		r.nbytes = nbytes;
		r.eom = eom;
		r.has_digest = has_digest;
		r.digest = digest;
		directed_rows.push_back(r);
	endtask

	function automatic int unsigned pick_gap();
		if (drain_phase || $urandom_range(0, 3) != 0)
			return 0;
		return $urandom_range(1, 18);
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d digest words still pending", $time,
				pending_digest_q.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_digest_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected item: expected none, got word %h index %0d last %b",
					$time, m_tdata[31:0], m_tdata[34:32], m_tlast);
			end else begin
				head = pending_digest_q.pop_front();
				if (m_tdata[31:0] !== head.word) begin
					errors++;
					$display("%0t: digest_word[%0d]: expected %h, got %h", $time, head.idx,
						head.word, m_tdata[31:0]);
				end
				if (m_tdata[34:32] !== head.idx) begin
					errors++;
					$display("%0t: word_index: expected %0d, got %0d", $time, head.idx,
						m_tdata[34:32]);
				end
				if (m_tlast !== head.last) begin
					errors++;
					$display("%0t: last_word at index %0d: expected %b, got %b", $time,
						head.idx, head.last, m_tlast);
				end
			end
		end
	end

	// receiver stalls in bursts
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!drain_phase && $urandom_range(0, 11) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(negedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	initial begin
		int i;
		int unsigned msg_len;
		bit calm;
		hash_restart();

		add_row(32'hFFFF_FFFF, 3'd0, 1'b1, 1'b1, DIGEST_EMPTY);   // empty message, junk ignored
		add_row(32'h6162_63FF, 3'd3, 1'b1, 1'b1, DIGEST_ABC);     // "abc", unused byte ignored
		add_row(32'h0000_0000, 3'd4, 1'b1, 1'b0, '0);
		add_row(32'hFFFF_FFFF, 3'd7, 1'b1, 1'b0, '0);             // count above four
		add_row(32'h1234_5678, 3'd1, 1'b0, 1'b0, '0);             // partial, no end mark
		add_row(32'h9ABC_DEF0, 3'd2, 1'b1, 1'b0, '0);
		add_row(32'h0F0F_0F0F, 3'd1, 1'b1, 1'b0, '0);
		// 14-word message: marker lands in slot 14, length spills into a second block
		for (i = 0; i < 13; i++)
			add_row(32'hA5A5_5A5A ^ (32'h0101_0101 * i), 3'(i % 8), 1'b0, 1'b0, '0);
		add_row(32'hC0FF_EE00, 3'd4, 1'b1, 1'b0, '0);
		add_row(32'h89AB_CDEF, 3'd5, 1'b1, 1'b0, '0);
		add_row(32'h7654_3210, 3'd6, 1'b1, 1'b0, '0);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[k])
			send_item(directed_rows[k].word, directed_rows[k].nbytes, directed_rows[k].eom,
				directed_rows[k].has_digest, directed_rows[k].digest, pick_gap());

		// hold off until all digests of the directed part are out
		s_tvalid <= 1'b0;
		while (pending_digest_q.size() != 0)
			@(negedge clk);

		while (items_sent < directed_rows.size() + RANDOM_ITEMS) begin
			if ($urandom_range(0, 7) == 0)
				msg_len = $urandom_range(17, 48);
			else
				msg_len = $urandom_range(1, 16);
			calm = ($urandom_range(0, 2) == 0);
			for (i = 0; i < msg_len; i++) begin
				drain_phase = (items_sent >= directed_rows.size() + DRAIN_AFTER);
				send_item(pick_word(), 3'($urandom_range(0, 7)), (i == msg_len - 1), 1'b0, '0,
					calm ? 0 : pick_gap());
			end
			if (!drain_phase && $urandom_range(0, 5) == 0) begin
				s_tvalid <= 1'b0;
				while (pending_digest_q.size() != 0)
					@(negedge clk);
			end
		end
		s_tvalid <= 1'b0;
		s_tlast <= 1'b0;

		while (pending_digest_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* sim.f */
sv/s256h_pkg.sv
sv/sha256_message_hash_unit.sv
tb/tb_top.sv
